### hw/rtl/oaht_pkg.sv
`timescale 1ns / 1ps

package oaht_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_PROBE_METHOD = 1'd0;
  localparam reg_idx_t REG_TABLE_SIZE   = 1'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  // Operation codes carried by each input item
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // Slot marks
  typedef logic [1:0] mark_t;
  localparam mark_t MARK_EMPTY = 2'd0;
  localparam mark_t MARK_USED  = 2'd1;
  localparam mark_t MARK_DEAD  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_READ,
    S_EVAL,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    div_step;
    logic    probe_init;
    logic    advance;
    logic    write_slot;
    logic    set_res;
    status_t res;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic mode_ins;
    logic mode_find;
    logic mode_del;
    logic mode_bad;
    logic load_full;
    logic div_done;
    logic mark_used;
    logic mark_empty;
    logic key_match;
    logic last_probe;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/oaht_ctrl.sv
`timescale 1ns / 1ps

module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = ST_MISS;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mode_bad) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_MISS;
          state_next  = S_FIN;
        end else if (sts.mode_ins && sts.load_full) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_FULL;
          state_next  = S_FIN;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_READ;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.mode_ins) begin
          if (!sts.mark_used) begin
            cmd.write_slot = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res        = ST_OK;
            state_next     = S_FIN;
          end else if (sts.last_probe) begin
            cmd.set_res = 1'b1;
            cmd.res     = ST_FULL;
            state_next  = S_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          if (sts.mark_used && sts.key_match) begin
            cmd.write_slot = sts.mode_del;
            cmd.set_res    = 1'b1;
            cmd.res        = ST_OK;
            state_next     = S_FIN;
          end else if (sts.mark_empty || sts.last_probe) begin
            cmd.set_res = 1'b1;
            cmd.res     = ST_MISS;
            state_next  = S_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/oaht_dp.sv
`timescale 1ns / 1ps

module oaht_dp
  import oaht_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 31,
  localparam int IDX_W   = $clog2(SLOTS),
  localparam int CNT_W   = $clog2(SLOTS + 1),
  localparam int IN_W    = ((2 + KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((2 + IDX_W + CNT_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [IN_W-1:0]      in_data,
  input  logic                 cfg_valid,
  input  reg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_data
);

  localparam int DC_W  = $clog2(KEY_BITS + 1);
  localparam int SZ_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int LW    = CNT_W + 4;
  localparam int WORD  = KEY_BITS + 2;
  localparam int PAD_W = OUT_W - (2 + IDX_W + CNT_W);

  // Configuration registers
  logic             probe_method;
  logic [CFG_W-1:0] table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_method <= 1'b0;
      table_size   <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROBE_METHOD: probe_method <= cfg_data[0];
        REG_TABLE_SIZE:   table_size   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective size: zero acts as one, anything above the slot count is clamped.
  logic [SZ_W-1:0]  size_ext;
  logic [CNT_W-1:0] size_eff;

  always_comb begin
    size_ext = SZ_W'(table_size);
    if (size_ext == '0) begin
      size_eff = CNT_W'(1);
    end else if (size_ext > SZ_W'(SLOTS)) begin
      size_eff = CNT_W'(SLOTS);
    end else begin
      size_eff = CNT_W'(size_ext);
    end
  end

  // Item registers and the remainder unit (one key bit per cycle).
  mode_t             mode_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] div_key;
  logic [CNT_W-1:0]  rem;
  logic [DC_W-1:0]   div_cnt;
  logic [CNT_W:0]    rem_shift;

  assign rem_shift = {rem, div_key[KEY_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_data[1:0];
      key_r   <= in_data[KEY_BITS+1:2];
      div_key <= in_data[KEY_BITS+1:2];
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_key <= div_key << 1;
      div_cnt <= div_cnt + DC_W'(1);
      if (rem_shift >= {1'b0, size_eff}) begin
        rem <= CNT_W'(rem_shift - {1'b0, size_eff});
      end else begin
        rem <= CNT_W'(rem_shift);
      end
    end
  end

  // Probe sequence: pos is the slot, step is the next offset increment.
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] probe_cnt;
  logic [CNT_W-1:0] step_init;
  logic [CNT_W:0]   pos_sum;
  logic [CNT_W:0]   pos_wrap;
  logic [CNT_W:0]   step_a;
  logic [CNT_W:0]   step_b;
  logic [CNT_W:0]   step_c;

  always_comb begin
    step_init = (size_eff == CNT_W'(1)) ? '0 : CNT_W'(1);
    pos_sum   = (CNT_W+1)'(pos) + (CNT_W+1)'(step);
    pos_wrap  = (pos_sum >= {1'b0, size_eff}) ? pos_sum - {1'b0, size_eff} : pos_sum;
    // The quadratic increment grows by two each probe, kept below the size.
    step_a    = (CNT_W+1)'(step) + (CNT_W+1)'(2);
    step_b    = (step_a >= {1'b0, size_eff}) ? step_a - {1'b0, size_eff} : step_a;
    step_c    = (step_b >= {1'b0, size_eff}) ? step_b - {1'b0, size_eff} : step_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pos       <= rem[IDX_W-1:0];
      step      <= step_init;
      probe_cnt <= '0;
    end else if (cmd.advance) begin
      pos       <= pos_wrap[IDX_W-1:0];
      probe_cnt <= probe_cnt + CNT_W'(1);
      if (probe_method) begin
        step <= CNT_W'(step_c);
      end
    end
  end

  // Slot store: mark and key per slot, one write and one registered read.
  logic [WORD-1:0]  mem [SLOTS];
  logic [WORD-1:0]  q;
  logic [IDX_W-1:0] clr_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [WORD-1:0]  mem_wd;
  mark_t            q_mark;
  logic [KEY_BITS-1:0] q_key;

  assign q_mark = q[WORD-1:KEY_BITS];
  assign q_key  = q[KEY_BITS-1:0];

  always_comb begin
    mem_we = cmd.clr_step || cmd.write_slot;
    if (cmd.clr_step) begin
      mem_wa = clr_addr;
      mem_wd = {MARK_EMPTY, {KEY_BITS{1'b0}}};
    end else if (mode_r == MODE_INSERT) begin
      mem_wa = pos;
      mem_wd = {MARK_USED, key_r};
    end else begin
      mem_wa = pos;
      mem_wd = {MARK_DEAD, q_key};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    q <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Live key count.
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = live_count;
    if (cmd.write_slot) begin
      if (mode_r == MODE_INSERT) begin
        count_next = live_count + CNT_W'(1);
      end else if (live_count != '0) begin
        count_next = live_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else begin
      live_count <= count_next;
    end
  end

  // Pending result and the output register.
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [CNT_W-1:0] res_count;
  status_t          out_status;
  logic [IDX_W-1:0] out_slot;
  logic [CNT_W-1:0] out_count;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res;
      res_slot   <= (cmd.res == ST_OK) ? pos : '0;
      res_count  <= count_next;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_count  <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {{PAD_W{1'b0}}, out_count, out_slot, out_status};

  // Status toward the controller.
  always_comb begin
    sts.clr_last   = (clr_addr == IDX_W'(SLOTS - 1));
    sts.mode_ins   = (mode_r == MODE_INSERT);
    sts.mode_find  = (mode_r == MODE_SEARCH) || (mode_r == MODE_DELETE);
    sts.mode_del   = (mode_r == MODE_DELETE);
    sts.mode_bad   = !sts.mode_ins && !sts.mode_find;
    sts.load_full  = (LW'(live_count) * LW'(10)) >= (LW'(size_eff) * LW'(7));
    sts.div_done   = (div_cnt == DC_W'(KEY_BITS));
    sts.mark_used  = (q_mark == MARK_USED);
    sts.mark_empty = (q_mark == MARK_EMPTY);
    sts.key_match  = (q_key == key_r);
    sts.last_probe = (probe_cnt == size_eff - CNT_W'(1));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

### hw/rtl/open_address_hash_table_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                               Moves
// s_axis    in         tvalid tready tdata                   item: mode, key
// m_axis    out        tvalid tready tdata                   item: status, slot_index, count
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// An item passes through acceptance, the mode and load check, the remainder steps over the
// key bits for key mod size, a step that starts probing, a registered slot read and an
// evaluation per probe, and a load into the output register; a refusal or unused mode
// goes from the check straight to the output register. After reset a clearing pass marks
// every slot empty; no item is taken during it, while configuration writes are.
// A result waiting at the output holds the next item only at its final cycle.

module open_address_hash_table_top
  import oaht_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 31,
  localparam int IDX_W   = $clog2(SLOTS),
  localparam int CNT_W   = $clog2(SLOTS + 1),
  localparam int IN_W    = ((2 + KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((2 + IDX_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // mode, key
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // status, slot_index, element_count
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  // Registers are written in any cycle.
  assign cfg_ready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  oaht_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // An item never follows another in the next cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted in two consecutive cycles");

  // Misses and refusals report slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)) |-> (m_axis_tdata[IDX_W+1:2] == '0))
    else $error("nonzero slot on a failed operation");

  // The live count never exceeds the slot count.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[IDX_W+CNT_W+1:IDX_W+2] <= CNT_W'(SLOTS)))
    else $error("element count above slot count");

  // No item is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !(cmd.load || cmd.write_slot || cmd.out_load))
    else $error("activity during clearing pass");
`endif

endmodule

### dv/tb_open_address_hash_table_top.sv
`timescale 1ns / 1ps

module tb_open_address_hash_table_top;
  import oaht_pkg::*;

  localparam int SLOTS    = 1024;
  localparam int KEY_BITS = 31;

  typedef struct {
    status_t     st;
    logic [9:0]  slot;
    logic [10:0] cnt;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // mode [1:0], key [32:2], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // status [1:0], slot_index [11:2], element_count [22:12]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_PROBE_METHOD;
  logic [10:0] cfg_data = '0;

  // Shadow copy of the table contents and registers.
  logic [30:0] shadow_keys [SLOTS];
  mark_t       shadow_marks [SLOTS];
  int unsigned shadow_count;
  logic        shadow_method;
  logic [10:0] shadow_size;

  table_result_t pending_results [$];
  logic [30:0]   stored_keys [$];
  int unsigned   mismatches;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   rx_pattern;
  int unsigned   rx_cycle;

  open_address_hash_table_top #(
    .SLOTS(SLOTS),
    .KEY_BITS(KEY_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Slot visited by probe number i of a key.
  function automatic int unsigned probe_target(logic [30:0] key, int unsigned i,
                                               int unsigned size);
    longint unsigned home;
    longint unsigned step;
    home = longint'(key) % size;
    step = shadow_method ? longint'(i) * longint'(i) : longint'(i);
    return int'((home + step) % size);
  endfunction

  // Apply one operation to the shadow table and return the answer it gives.
  function automatic table_result_t table_op(mode_t mode, logic [30:0] key);
    table_result_t r;
    int unsigned size;
    int unsigned s;
    size = shadow_size;
    if (size == 0) size = 1;
    if (size > SLOTS) size = SLOTS;
    r.st = ST_MISS;
    r.slot = '0;
    if (mode == MODE_INSERT) begin
      r.st = ST_FULL;
      if (shadow_count * 10 < size * 7) begin
        for (int unsigned i = 0; i < size; i++) begin
          s = probe_target(key, i, size);
          if (shadow_marks[s] != MARK_USED) begin
            shadow_keys[s] = key;
            shadow_marks[s] = MARK_USED;
            shadow_count++;
            r.st = ST_OK;
            r.slot = s[9:0];
            break;
          end
        end
      end
    end else if (mode == MODE_SEARCH || mode == MODE_DELETE) begin
      for (int unsigned i = 0; i < size; i++) begin
        s = probe_target(key, i, size);
        if (shadow_marks[s] == MARK_USED && shadow_keys[s] == key) begin
          r.st = ST_OK;
          r.slot = s[9:0];
          if (mode == MODE_DELETE) begin
            shadow_marks[s] = MARK_DEAD;
            if (shadow_count > 0) shadow_count--;
          end
          break;
        end
        if (shadow_marks[s] == MARK_EMPTY) break;
      end
    end
    r.cnt = shadow_count[10:0];
    return r;
  endfunction

  // Receiver: stall on the pattern chosen by the current test.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_pattern)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        m_axis_tready <= ((rx_cycle % 11) < 4);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 1) != 0);
      end
    endcase
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    table_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item %h", m_axis_tdata);
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== e.st || m_axis_tdata[11:2] !== e.slot ||
            m_axis_tdata[22:12] !== e.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                     results_seen, e.st, e.slot, e.cnt, m_axis_tdata[1:0],
                     m_axis_tdata[11:2], m_axis_tdata[22:12]);
        end
      end
    end
  end

  // Send one item and record its expected result when it is accepted.
  task automatic send_item(mode_t mode, logic [30:0] key);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, key, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(table_op(mode, key));
    if (mode == MODE_INSERT) stored_keys.push_back(key);
    items_sent++;
  endtask

  task automatic idle_input(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every expected result has come back.
  task automatic drain();
    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PROBE_METHOD) shadow_method = value[0];
    else shadow_size = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_table(logic method, logic [10:0] size);
    drain();
    cfg_write(REG_PROBE_METHOD, {10'd0, method});
    cfg_write(REG_TABLE_SIZE, size);
  endtask

  // Collisions, tombstones, duplicates, load bound, misses and the unused mode.
  task automatic test_linear_basics();
    rx_pattern = 0;
    set_table(1'b0, 11'd8);
    send_item(MODE_INSERT, 31'd0);
    send_item(MODE_INSERT, 31'd8);
    send_item(MODE_INSERT, 31'd16);
    send_item(MODE_SEARCH, 31'd16);
    send_item(MODE_DELETE, 31'd8);
    send_item(MODE_SEARCH, 31'd16);
    send_item(MODE_DELETE, 31'd8);
    send_item(MODE_INSERT, 31'd24);
    send_item(MODE_INSERT, 31'd0);
    send_item(MODE_INSERT, 31'h7FFFFFFF);
    send_item(MODE_SEARCH, 31'h7FFFFFFF);
    send_item(MODE_INSERT, 31'd5);
    send_item(MODE_INSERT, 31'd6);
    send_item(mode_t'(2'd3), 31'd0);
    send_item(MODE_SEARCH, 31'd3);
    send_item(MODE_DELETE, 31'd0);
    send_item(MODE_SEARCH, 31'd0);
  endtask

  // Quadratic probing that runs out of reachable slots below the load bound.
  task automatic test_quadratic_no_free();
    rx_pattern = 1;
    set_table(1'b1, 11'd5);
    send_item(MODE_INSERT, 31'd0);
    send_item(MODE_INSERT, 31'd5);
    send_item(MODE_INSERT, 31'd10);
    send_item(MODE_INSERT, 31'd15);
    send_item(MODE_SEARCH, 31'd15);
    send_item(MODE_SEARCH, 31'd10);
  endtask

  // Size zero acts as one, an oversized value as the full table.
  task automatic test_size_limits();
    rx_pattern = 2;
    set_table(1'b0, 11'd0);
    send_item(MODE_INSERT, 31'd77);
    send_item(MODE_INSERT, 31'd78);
    send_item(MODE_SEARCH, 31'd77);
    set_table(1'b1, 11'h7FF);
    send_item(MODE_INSERT, 31'h7FFFFFFF);
    send_item(MODE_SEARCH, 31'd77);
    send_item(MODE_DELETE, 31'h7FFFFFFF);
  endtask

  // Random mix on one table setting; keys mostly come from earlier inserts.
  task automatic test_random_phase(logic method, logic [10:0] size, int unsigned count);
    int unsigned burst;
    int unsigned pick;
    mode_t mode;
    logic [30:0] key;
    rx_pattern = $urandom_range(0, 3);
    set_table(method, size);
    burst = $urandom_range(1, 12);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) mode = MODE_INSERT;
      else if (pick < 75) mode = MODE_SEARCH;
      else if (pick < 97) mode = MODE_DELETE;
      else mode = mode_t'(2'd3);
      if (stored_keys.size() != 0 && $urandom_range(0, 99) < 55)
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else if ($urandom_range(0, 1) != 0)
        key = 31'($urandom);
      else
        key = 31'($urandom_range(0, 4 * size + 3));
      send_item(mode, key);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    rx_pattern = 0;
    rx_cycle = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_keys[i] = '0;
      shadow_marks[i] = MARK_EMPTY;
    end
    shadow_count = 0;
    shadow_method = 1'b0;
    shadow_size = SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_linear_basics();
    test_quadratic_no_free();
    test_size_limits();
    test_random_phase(1'b0, 11'd16, 110);
    test_random_phase(1'b1, 11'd13, 110);
    test_random_phase(1'b0, 11'd1024, 100);
    test_random_phase(1'b1, 11'd1024, 100);
    test_random_phase(1'b0, 11'd37, 100);
    test_random_phase(1'b1, 11'd1, 40);
    test_random_phase(1'b1, 11'd64, 100);
    test_random_phase(1'b0, 11'h7FF, 160);
    drain();
    repeat (40) @(posedge clk);

    $display("Covered insert, search, delete and unused mode over linear and quadratic");
    $display("probing: %0d items, %0d results, sizes from zero to above full.",
             items_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("open_address_hash_table_top: match");
    end else begin
      $display("open_address_hash_table_top: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("open_address_hash_table_top: mismatch");
    $finish;
  end

endmodule
